FILE: rtl/tube_display_string_loader_assert.svh
// assertion macros for the string loader
`ifndef TUBE_DISPLAY_STRING_LOADER_ASSERT_SVH
`define TUBE_DISPLAY_STRING_LOADER_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, idle while reset is high
`define TDSL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tdsl assertion failed");
// clocked check that also holds during reset
`define TDSL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tdsl assertion failed");
`else
`define TDSL_ASSERT(lbl, clk, rst, prop)
`define TDSL_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/tdsl_pkg.sv
package tdsl_pkg;

   localparam int IMAGE_BITS = 40;
   localparam int TUBE_COUNT = 6;
   localparam int POS_W      = 6;
   localparam int TUBE_W     = 3;

   typedef logic [POS_W-1:0] reg_num_type;

   // driver register numbers of each tube's code bits, code bit 0 first
   localparam reg_num_type TUBE_REGS [TUBE_COUNT][4] = '{
      '{6'd3,  6'd4,  6'd5,  6'd0 },
      '{6'd8,  6'd10, 6'd11, 6'd9 },
      '{6'd14, 6'd13, 6'd18, 6'd15},
      '{6'd16, 6'd22, 6'd23, 6'd21},
      '{6'd27, 6'd29, 6'd30, 6'd28},
      '{6'd32, 6'd38, 6'd39, 6'd37}
   };
   localparam reg_num_type LAMP_REGS  [TUBE_COUNT] = '{6'd2, 6'd7, 6'd17, 6'd20, 6'd26, 6'd34};
   localparam reg_num_type POINT_REGS [TUBE_COUNT] = '{6'd1, 6'd6, 6'd12, 6'd19, 6'd25, 6'd33};
   localparam reg_num_type ANODE_REG  = 6'd35;
   localparam reg_num_type LAST_POS   = reg_num_type'(IMAGE_BITS - 1);

   // characters
   localparam logic [7:0] CHAR_BLANK = 8'h58;  // 'X'
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_POINT = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_SPACE = 8'h20;  // ' '

   localparam logic [3:0] CODE_BLANK = 4'd10;

   typedef enum logic [2:0] {
      PH_DIGIT = 3'b001,
      PH_LED   = 3'b010,
      PH_SKIP  = 3'b100
   } phase_type;

   // driver register r sits at image bit IMAGE_BITS-1-r
   function automatic reg_num_type img_idx(input reg_num_type reg_num);
      img_idx = LAST_POS - reg_num;
   endfunction

endpackage

FILE: rtl/tube_display_string_loader.sv
// channel | beat contents                                  | direction
// req     | tdata[7:0] char_code, tlast end_of_string       | in
// rsp     | tdata[0] serial_bit, tdata[6:1] bit_position,   | out
//         | tlast latch_pulse                               |
// a character is parsed in the cycle it is accepted
// a character with tlast loads the 40-bit output shifter, which then sends one
// bit per rsp beat; req is held off for those 40 beats (plus any rsp stalls)
// reset clears the image, the parser and the shifter control; no clearing pass
// rsp stalls only freeze the shifter; they never drop or repeat a bit
`include "tube_display_string_loader_assert.svh"

module tube_display_string_loader
   import tdsl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_string
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] serial_bit, [6:1] bit_position, [7] zero
   output logic       rsp_tlast    // latch_pulse
);

   logic [IMAGE_BITS-1:0] image_ff, image_in;
   logic [IMAGE_BITS-1:0] shift_ff, shift_in;
   phase_type             phase_ff, phase_in;
   logic [TUBE_W-1:0]     tube_ff, tube_in;
   logic [TUBE_W-1:0]     lamp_ff, lamp_in;
   logic                  anode_ff, anode_in;
   logic                  start_ff, start_in;
   logic                  busy_ff, busy_in;
   reg_num_type           pos_ff, pos_in;

   logic       req_beat;
   logic       rsp_beat;
   logic       last_beat;
   logic       is_digit;
   logic [3:0] digit;
   logic [3:0] digit_code;

   assign req_tready = ~busy_ff;
   assign req_beat   = req_tvalid & req_tready;
   assign rsp_beat   = rsp_tvalid & rsp_tready;
   assign last_beat  = rsp_beat & (pos_ff == LAST_POS);

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {1'b0, pos_ff, shift_ff[0]};
   assign rsp_tlast  = (pos_ff == LAST_POS);

   // digit decode and remap
   assign is_digit   = (req_tdata >= CHAR_ZERO) && (req_tdata <= CHAR_NINE);
   assign digit      = 4'(req_tdata - CHAR_ZERO);
   assign digit_code = (digit <= 4'd1) ? 4'(4'd1 - digit) : 4'(4'd11 - digit);

   // character parser
   always_comb begin
      image_in = image_ff;
      phase_in = phase_ff;
      tube_in  = tube_ff;
      lamp_in  = lamp_ff;
      anode_in = anode_ff;
      start_in = start_ff;
      if (req_beat) begin
         // first character of a string clears the points
         if (start_ff) begin
            for (int k = 0; k < TUBE_COUNT; k++) begin
               image_in[img_idx(POINT_REGS[k])] = 1'b0;
            end
            start_in = 1'b0;
         end
         unique case (phase_ff)
            PH_DIGIT: begin
               if (req_tdata == CHAR_BLANK || is_digit) begin
                  if (tube_ff >= TUBE_W'(TUBE_COUNT)) begin
                     phase_in = PH_SKIP;
                  end else begin
                     for (int b = 0; b < 4; b++) begin
                        image_in[img_idx(TUBE_REGS[tube_ff][b])] =
                           is_digit ? digit_code[b] : CODE_BLANK[b];
                     end
                     tube_in = TUBE_W'(tube_ff + 1'b1);
                     if (is_digit) begin
                        anode_in = 1'b1;
                     end
                  end
               end else if (req_tdata == CHAR_POINT) begin
                  if (tube_ff == '0 || tube_ff > TUBE_W'(TUBE_COUNT)) begin
                     phase_in = PH_SKIP;
                  end else begin
                     image_in[img_idx(POINT_REGS[TUBE_W'(tube_ff - 1'b1)])] = 1'b1;
                     anode_in = 1'b1;
                  end
               end else if (req_tdata == CHAR_SPACE) begin
                  phase_in = PH_LED;
               end
            end
            PH_SKIP: begin
               if (req_tdata == CHAR_SPACE) begin
                  phase_in = PH_LED;
               end
            end
            PH_LED: begin
               if (lamp_ff < TUBE_W'(TUBE_COUNT)) begin
                  image_in[img_idx(LAMP_REGS[lamp_ff])] = (req_tdata != CHAR_ZERO);
                  lamp_in = TUBE_W'(lamp_ff + 1'b1);
               end
            end
            default: ;
         endcase
         // end of string: anode bit, then parser back to its start
         if (req_tlast) begin
            image_in[img_idx(ANODE_REG)] = anode_in;
            phase_in = PH_DIGIT;
            tube_in  = '0;
            lamp_in  = '0;
            anode_in = 1'b0;
            start_in = 1'b1;
         end
      end
   end

   // output shifter, lsb first
   always_comb begin
      shift_in = shift_ff;
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      if (req_beat && req_tlast) begin
         shift_in = image_in;
         busy_in  = 1'b1;
         pos_in   = '0;
      end else if (rsp_beat) begin
         shift_in = {1'b0, shift_ff[IMAGE_BITS-1:1]};
         if (last_beat) begin
            busy_in = 1'b0;
            pos_in  = '0;
         end else begin
            pos_in = reg_num_type'(pos_ff + 1'b1);
         end
      end
   end

   // control and image registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_ff <= '0;
         phase_ff <= PH_DIGIT;
         tube_ff  <= '0;
         lamp_ff  <= '0;
         anode_ff <= 1'b0;
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
         pos_ff   <= '0;
      end else begin
         image_ff <= image_in;
         phase_ff <= phase_in;
         tube_ff  <= tube_in;
         lamp_ff  <= lamp_in;
         anode_ff <= anode_in;
         start_ff <= start_in;
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
      end
   end

   // shifter payload
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
   end

   // checks
   `TDSL_ASSERT(a_burst_starts, clock, reset, req_beat && req_tlast |=> busy_ff && pos_ff == '0)
   `TDSL_ASSERT(a_burst_ends, clock, reset, last_beat |=> !busy_ff)
   `TDSL_ASSERT(a_parser_rearmed, clock, reset, req_beat && req_tlast |=> start_ff && phase_ff == PH_DIGIT && tube_ff == '0 && !anode_ff)
   `TDSL_ASSERT(a_pos_range, clock, reset, busy_ff |-> pos_ff <= LAST_POS)
   `TDSL_ASSERT_ALWAYS(a_idle_pos, clock, !busy_ff |-> pos_ff == '0)

endmodule
